/* src/spq_pkg.sv */
// shared types and request/status codes for the sorted priority queue
package spq_pkg;
  localparam logic [2:0] REQ_ENQ   = 3'd0;
  localparam logic [2:0] REQ_DEQ   = 3'd1;
  localparam logic [2:0] REQ_CHG   = 3'd2;
  localparam logic [2:0] REQ_CLR   = 3'd3;
  localparam logic [2:0] REQ_PEEK  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_NOTAG  = 2'd3;

  localparam int PRI_BITS = 32;
endpackage

/* src/spq_ram.sv */
// generic single-port-write, single-read ram with registered read
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* src/sorted_priority_queue_unit.sv */
// Sorted priority queue, lowest priority first, entries kept in one RAM in
// ascending order with slot 0 as the head. Each request returns one result
// word. Enqueue walks the list from the tail toward the head, one entry per
// cycle through the RAM read port, moving each larger entry up by one.
// Dequeue shifts all remaining entries down one per cycle. A priority change
// scans from the head for the tag, closes the gap, then re-inserts. One
// request is in work at a time; the next is taken while the last result word
// waits on the output.
module sorted_priority_queue_unit #(
  parameter int DEPTH    = 64,
  parameter int TAG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_item_tag,
  input  logic signed [31:0] in_item_priority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_out_tag,
  output logic signed [31:0] out_out_priority,
  output logic [6:0]  out_entry_count,
  output logic        out_is_empty,
  output logic [1:0]  out_status
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int EW = TAG_BITS + PRI_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;  // walk down from tail, shift up
  localparam logic [2:0] S_DEL   = 3'd2;  // walk up from gap, shift down
  localparam logic [2:0] S_FIND  = 3'd3;  // scan for a tag
  localparam logic [2:0] S_HEAD  = 3'd4;  // read head for dequeue/peek
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_FIXUP = 3'd6;  // new entry goes into the head

  logic [2:0]          state_r, state_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [2:0]          req_r, req_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic signed [PRI_BITS-1:0] pri_r, pri_nxt;
  logic [OW-1:0]       idx_r, idx_nxt;   // slot being read, or in S_DEL the gap slot
  logic                rdv_r, rdv_nxt;   // read data valid this cycle
  logic [1:0]          st_r, st_nxt;
  logic [31:0]         otag_r, otag_nxt;
  logic signed [31:0]  opri_r, opri_nxt;

  logic                ovalid_r, ovalid_nxt;
  logic [31:0]         rtag_r, rtag_nxt;
  logic signed [31:0]  rpri_r, rpri_nxt;
  logic [6:0]          rcnt_r, rcnt_nxt;
  logic                remp_r, remp_nxt;
  logic [1:0]          rst_r, rst_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;
  logic [TAG_BITS-1:0] rd_tag;
  logic signed [PRI_BITS-1:0] rd_pri;

  spq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign rd_tag = rd_data[EW-1:PRI_BITS];
  assign rd_pri = rd_data[PRI_BITS-1:0];

  assign in_ready = (state_r == S_IDLE);
  assign out_valid        = ovalid_r;
  assign out_out_tag      = rtag_r;
  assign out_out_priority = rpri_r;
  assign out_entry_count  = rcnt_r;
  assign out_is_empty     = remp_r;
  assign out_status       = rst_r;

  // sequencer
  always_comb begin
    logic [TAG_BITS-1:0] itag;
    state_nxt = state_r; occ_nxt = occ_r; req_nxt = req_r; tag_nxt = tag_r;
    pri_nxt = pri_r; idx_nxt = idx_r; rdv_nxt = 1'b0; st_nxt = st_r;
    otag_nxt = otag_r; opri_nxt = opri_r;
    ovalid_nxt = ovalid_r; rtag_nxt = rtag_r; rpri_nxt = rpri_r;
    rcnt_nxt = rcnt_r; remp_nxt = remp_r; rst_nxt = rst_r;
    wr_en = 1'b0; wr_addr = '0; wr_data = {tag_r, pri_r}; rd_addr = '0;
    itag = TAG_BITS'(in_item_tag);

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_req_type; tag_nxt = itag; pri_nxt = in_item_priority;
          st_nxt = ST_OK; otag_nxt = '0; opri_nxt = '0;
          state_nxt = S_DONE;
          unique case (in_req_type)
            REQ_ENQ: begin
              if (occ_r >= OW'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else if (occ_r == '0) begin
                wr_en = 1'b1; wr_addr = '0; wr_data = {itag, in_item_priority};
                occ_nxt = occ_r + 1'b1;
              end else begin
                rd_addr = AW'(occ_r - 1'b1); idx_nxt = occ_r - 1'b1;
                rdv_nxt = 1'b1; state_nxt = S_INS;
              end
            end
            REQ_DEQ, REQ_PEEK: begin
              if (occ_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                rd_addr = '0; rdv_nxt = 1'b1; state_nxt = S_HEAD;
              end
            end
            REQ_CHG: begin
              if (occ_r == '0) begin
                st_nxt = ST_NOTAG;
              end else begin
                rd_addr = '0; idx_nxt = '0; rdv_nxt = 1'b1; state_nxt = S_FIND;
              end
            end
            REQ_CLR: occ_nxt = '0;
            default: ;
          endcase
        end
      end
      S_HEAD: begin
        otag_nxt = 32'(rd_tag); opri_nxt = rd_pri;
        if (req_r == REQ_DEQ) begin
          idx_nxt = '0;
          if (occ_r > OW'(1)) begin
            rd_addr = AW'(1); rdv_nxt = 1'b1; state_nxt = S_DEL;
          end else begin
            occ_nxt = occ_r - 1'b1; state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIND: begin
        if (rd_tag == tag_r) begin
          // close the gap at idx
          if (idx_r + 1'b1 < occ_r) begin
            rd_addr = AW'(idx_r + 1'b1); rdv_nxt = 1'b1; state_nxt = S_DEL;
          end else begin
            occ_nxt = occ_r - 1'b1;
            if (occ_r == OW'(1)) begin
              wr_en = 1'b1; wr_addr = '0; occ_nxt = occ_r; state_nxt = S_DONE;
            end else begin
              rd_addr = AW'(occ_r - 2'd2); idx_nxt = occ_r - 2'd2;
              rdv_nxt = 1'b1; state_nxt = S_INS;
            end
          end
        end else if (idx_r + 1'b1 < occ_r) begin
          idx_nxt = idx_r + 1'b1; rd_addr = AW'(idx_r + 1'b1);
          rdv_nxt = 1'b1;
        end else begin
          st_nxt = ST_NOTAG; state_nxt = S_DONE;
        end
      end
      S_DEL: begin
        // move slot idx+1 down to idx
        wr_en = 1'b1; wr_addr = AW'(idx_r); wr_data = rd_data;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 2'd2 < occ_r) begin
          rd_addr = AW'(idx_r + 2'd2); rdv_nxt = 1'b1;
        end else begin
          occ_nxt = occ_r - 1'b1;
          if (req_r == REQ_CHG) begin
            if (occ_r == OW'(1)) begin
              state_nxt = S_DONE;
            end else begin
              // new tail is being written now; its old copy still sits one up
              rd_addr = AW'(occ_r - 1'b1); idx_nxt = occ_r - 2'd2;
              rdv_nxt = 1'b1; state_nxt = S_INS;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INS: begin
        // entry at idx: if larger, move up one and continue downward
        if (rd_pri > pri_r) begin
          wr_en = 1'b1; wr_addr = AW'(idx_r + 1'b1); wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_FIXUP;
          end else begin
            idx_nxt = idx_r - 1'b1; rd_addr = AW'(idx_r - 1'b1); rdv_nxt = 1'b1;
          end
        end else begin
          wr_en = 1'b1; wr_addr = AW'(idx_r + 1'b1);
          occ_nxt = occ_r + 1'b1; state_nxt = S_DONE;
        end
      end
      S_FIXUP: begin
        wr_en = 1'b1; wr_addr = '0; occ_nxt = occ_r + 1'b1; state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1; rtag_nxt = otag_r; rpri_nxt = opri_r;
          rcnt_nxt = 7'(occ_r); remp_nxt = (occ_r == '0); rst_nxt = st_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; occ_r <= '0; ovalid_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; occ_r <= occ_nxt; ovalid_r <= ovalid_nxt;
      rdv_r <= rdv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt; tag_r <= tag_nxt; pri_r <= pri_nxt; idx_r <= idx_nxt;
    st_r <= st_nxt; otag_r <= otag_nxt; opri_r <= opri_nxt;
    rtag_r <= rtag_nxt; rpri_r <= rpri_nxt; rcnt_r <= rcnt_nxt;
    remp_r <= remp_nxt; rst_r <= rst_nxt;
  end

  // checks
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(DEPTH)) else $error("occupancy over depth");
  a_read_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS || state_r == S_DEL || state_r == S_FIND ||
     state_r == S_HEAD) |-> rdv_r) else $error("ram data used without read");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("took two requests");
endmodule

/* dv/tb_sorted_priority_queue_unit.sv */
// testbench for the sorted priority queue: random and directed requests checked against a queue model
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int QDEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]         req;
    logic [31:0]        tag;
    logic signed [31:0] pri;
  } req_word_t;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [31:0] pri;
    logic [6:0]         count;
    logic               empty;
    logic [1:0]         status;
  } resp_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_req_type;
  logic [31:0] in_item_tag;
  logic signed [31:0] in_item_priority;
  logic out_valid;
  logic out_ready;
  logic [31:0] out_out_tag;
  logic signed [31:0] out_out_priority;
  logic [6:0] out_entry_count;
  logic out_is_empty;
  logic [1:0] out_status;

  sorted_priority_queue_unit dut (.*);

  // model state of the sorted list
  logic [31:0]        mdl_tag [QDEPTH];
  logic signed [31:0] mdl_pri [QDEPTH];
  int                 mdl_cnt;

  req_word_t  pending_words[$];
  resp_word_t expected_resp[$];
  int  fail_count;
  int  resp_seen;
  int  cycle_count;
  bit  idle_enable;
  bit  hold_off;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sorted insert after every entry of equal or lower priority
  task automatic list_insert(input logic [31:0] t, input logic signed [31:0] p);
    int pos;
    pos = 0;
    while (pos < mdl_cnt && mdl_pri[pos] <= p) pos++;
    for (int i = mdl_cnt; i > pos; i--) begin
      mdl_tag[i] = mdl_tag[i-1];
      mdl_pri[i] = mdl_pri[i-1];
    end
    mdl_tag[pos] = t;
    mdl_pri[pos] = p;
    mdl_cnt++;
  endtask

  task automatic list_remove(input int pos);
    for (int i = pos; i + 1 < mdl_cnt; i++) begin
      mdl_tag[i] = mdl_tag[i+1];
      mdl_pri[i] = mdl_pri[i+1];
    end
    mdl_cnt--;
  endtask

  // compute the response of one accepted word
  task automatic predict_queue_resp(input req_word_t w);
    resp_word_t r;
    r = '0;
    case (w.req)
      REQ_ENQ: begin
        if (mdl_cnt >= QDEPTH) r.status = ST_FULL;
        else list_insert(w.tag, w.pri);
      end
      REQ_DEQ, REQ_PEEK: begin
        if (mdl_cnt == 0) r.status = ST_EMPTY;
        else begin
          r.tag = mdl_tag[0];
          r.pri = mdl_pri[0];
          if (w.req == REQ_DEQ) list_remove(0);
        end
      end
      REQ_CHG: begin
        r.status = ST_NOTAG;
        for (int i = 0; i < mdl_cnt; i++) begin
          if (mdl_tag[i] == w.tag) begin
            list_remove(i);
            list_insert(w.tag, w.pri);
            r.status = ST_OK;
            break;
          end
        end
      end
      REQ_CLR: mdl_cnt = 0;
      default: ;
    endcase
    r.count = mdl_cnt[6:0];
    r.empty = (mdl_cnt == 0);
    expected_resp.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, resp_seen);
    fail_count++;
  endtask

  function automatic req_word_t mk(input logic [2:0] r, input logic [31:0] t,
                                   input logic [31:0] p);
    req_word_t w;
    w.req = r;
    w.tag = t;
    w.pri = p;
    return w;
  endfunction

  // random priority: narrow range most of the time so ties happen
  function automatic logic [31:0] rand_pri();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 15)) - 8;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_queue_resp(mk(in_req_type, in_item_tag, in_item_priority));
      if (pending_words.size() > 0 && !hold_off &&
          !(idle_enable && $urandom_range(0, 99) < 15)) begin
        req_word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_req_type <= w.req;
        in_item_tag <= w.tag;
        in_item_priority <= w.pri;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resp.size() == 0) begin
          report_mismatch("unexpected result word", 32'h0, 32'h0);
        end else begin
          resp_word_t e;
          e = expected_resp.pop_front();
          if (out_out_tag !== e.tag) report_mismatch("tag", out_out_tag, e.tag);
          if (out_out_priority !== e.pri) report_mismatch("priority", out_out_priority, e.pri);
          if (out_entry_count !== e.count)
            report_mismatch("count", 32'(out_entry_count), 32'(e.count));
          if (out_is_empty !== e.empty)
            report_mismatch("empty", 32'(out_is_empty), 32'(e.empty));
          if (out_status !== e.status)
            report_mismatch("status", 32'(out_status), 32'(e.status));
        end
        resp_seen++;
      end
      out_ready <= !(idle_enable && $urandom_range(0, 99) < 15);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [31:0] tags[$];
    int n;
    in_valid = 1'b0;
    in_req_type = REQ_ENQ;
    in_item_tag = '0;
    in_item_priority = '0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    mdl_cnt = 0;
    fail_count = 0;
    resp_seen = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    hold_off = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extremes, ties, change, clear, unused codes
    pending_words.push_back(mk(REQ_DEQ, 0, 0));
    pending_words.push_back(mk(REQ_PEEK, 0, 0));
    pending_words.push_back(mk(REQ_CHG, 32'h5, 1));
    pending_words.push_back(mk(REQ_ENQ, 32'hffffffff, 32'h7fffffff));
    pending_words.push_back(mk(REQ_ENQ, 32'h0, 32'h80000000));
    pending_words.push_back(mk(REQ_ENQ, 32'haaaa5555, 0));
    pending_words.push_back(mk(REQ_ENQ, 32'h5555aaaa, 0));
    pending_words.push_back(mk(REQ_PEEK, 0, 0));
    pending_words.push_back(mk(REQ_CHG, 32'hffffffff, 32'h80000000));
    pending_words.push_back(mk(REQ_CHG, 32'h12345678, 3));
    pending_words.push_back(mk(REQ_CHG, 32'haaaa5555, 0));
    pending_words.push_back(mk(3'd5, 32'hffffffff, 32'hffffffff));
    pending_words.push_back(mk(3'd6, 0, 0));
    pending_words.push_back(mk(3'd7, 1, 1));
    pending_words.push_back(mk(REQ_DEQ, 0, 0));
    pending_words.push_back(mk(REQ_DEQ, 0, 0));
    pending_words.push_back(mk(REQ_CLR, 0, 0));
    pending_words.push_back(mk(REQ_CLR, 0, 0));
    pending_words.push_back(mk(REQ_DEQ, 0, 0));

    // fill to full, overflow, then wait until every expected result word is checked
    for (int i = 0; i < QDEPTH + 2; i++)
      pending_words.push_back(mk(REQ_ENQ, $urandom(), rand_pri()));
    pending_words.push_back(mk(REQ_PEEK, 0, 0));
    wait (pending_words.size() == 0);
    hold_off = 1'b1;
    wait (!in_valid && expected_resp.size() == 0);
    hold_off = 1'b0;
    for (int i = 0; i < QDEPTH + 1; i++) pending_words.push_back(mk(REQ_DEQ, 0, 0));

    // random mix, tags drawn mostly from recently enqueued ones
    for (int i = 0; i < 1150; i++) begin
      logic [31:0] t;
      n = $urandom_range(0, 99);
      if (i == 400) begin
        wait (pending_words.size() == 0);
        idle_enable = 1'b0;
      end
      if (i == 700) begin
        wait (pending_words.size() == 0);
        idle_enable = 1'b1;
      end
      t = (tags.size() > 0 && $urandom_range(0, 3) != 0) ?
          tags[$urandom_range(0, tags.size() - 1)] : $urandom();
      if (n < 45) begin
        t = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 31);
        tags.push_back(t);
        if (tags.size() > 80) void'(tags.pop_front());
        pending_words.push_back(mk(REQ_ENQ, t, rand_pri()));
      end else if (n < 70) pending_words.push_back(mk(REQ_DEQ, $urandom(), $urandom()));
      else if (n < 85) pending_words.push_back(mk(REQ_CHG, t, rand_pri()));
      else if (n < 95) pending_words.push_back(mk(REQ_PEEK, $urandom(), $urandom()));
      else if (n < 97) pending_words.push_back(mk(REQ_CLR, $urandom(), $urandom()));
      else pending_words.push_back(mk(3'($urandom_range(5, 7)), $urandom(), $urandom()));
    end

    wait (pending_words.size() == 0 && !in_valid && expected_resp.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d result words: enqueue with ties, dequeue, peek, change,", resp_seen);
    $display("clear, full and empty rejects, missing tags and unused codes");
    if (fail_count == 0 && expected_resp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
